@@ hw/rtl/blp_pkg.sv @@
`default_nettype none

package blp_pkg;

  localparam int BufferBytesDef   = 4096;
  localparam int MaxFieldWidthDef = 32;

  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 2;
  localparam int OffsetW   = 16;
  localparam int ValueW    = 32;
  localparam int WidthW    = 6;
  localparam int IndexW    = 12;
  localparam int CountW    = 16;
  localparam int ByteW     = 8;
  localparam int MaxBytes  = 5;
  localparam int SpanW     = MaxBytes * ByteW;
  localparam int ByteCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartOffset = 2'd0,
    CfgWindowLen   = 2'd1,
    CfgLengthToEnd = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatNone        = 2'd0,
    StatBadGeometry = 2'd1,
    StatBadWidth    = 2'd2,
    StatExhausted   = 2'd3
  } status_e;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdAlign = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

@@ hw/rtl/blp_item_if.sv @@
`default_nettype none

interface blp_item_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [blp_pkg::ValueW-1:0] field_value;
  logic [blp_pkg::WidthW-1:0] field_width;

  modport source (output valid, command, field_value, field_width, input ready);
  modport sink   (input valid, command, field_value, field_width, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/blp_result_if.sv @@
`default_nettype none

interface blp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       byte_write_valid;
  logic [blp_pkg::IndexW-1:0] wr_index;
  logic [blp_pkg::ByteW-1:0]  byte_data;
  logic [blp_pkg::ByteW-1:0]  byte_mask;
  logic [1:0]                 status;
  logic                       last;
  logic [blp_pkg::CountW-1:0] bits_done;
  logic [blp_pkg::CountW-1:0] bits_free;
  logic                       on_boundary;

  modport source (output valid, byte_write_valid, wr_index, byte_data, byte_mask, status,
                  last, bits_done, bits_free, on_boundary, input ready);
  modport sink   (input valid, byte_write_valid, wr_index, byte_data, byte_mask, status,
                  last, bits_done, bits_free, on_boundary, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bounded_lsb_bit_packer_unit.sv @@
`default_nettype none

// channel   dir  payload                                            transaction
// item_i    in   command, field_value, field_width                  valid & ready
// result_o  out  byte write, status, last, counters after the item  valid & ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                    cfg_we_i high
//
// an item is checked and its bytes prepared in the cycle it is accepted, into a work register
// the work register emits one result per cycle into a free output register; 1 to 5 per item
// a new item is taken in the cycle the previous item's last result moves to the output register
// reset clears the valid flags, the position and the configuration (length_to_end set)
// a stalled output holds its register and a busy work register; no clearing pass

module bounded_lsb_bit_packer_unit #(
  parameter int BUFFER_BYTES    = blp_pkg::BufferBytesDef,
  parameter int MAX_FIELD_WIDTH = blp_pkg::MaxFieldWidthDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [blp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [blp_pkg::CfgDataW-1:0]     cfg_data_i,
  blp_item_if.sink                         item_i,
  blp_result_if.source                     result_o
);

  localparam int AvailBits = BUFFER_BYTES * 8;
  localparam int AvailW    = $clog2(AvailBits + 1);
  localparam int PosW      = (AvailW > blp_pkg::OffsetW) ? AvailW : blp_pkg::OffsetW;
  localparam logic [PosW-1:0] Avail = PosW'(AvailBits);

  typedef struct packed {
    logic                            wr;
    logic [blp_pkg::SpanW-1:0]       data;
    logic [blp_pkg::SpanW-1:0]       mask;
    logic [blp_pkg::IndexW-1:0]      index;
    logic [blp_pkg::ByteCntW-1:0]    cnt;
    blp_pkg::status_e                status;
    logic [blp_pkg::CountW-1:0]      written;
    logic [blp_pkg::CountW-1:0]      remaining;
    logic                            aligned;
  } work_t;

  logic [blp_pkg::OffsetW-1:0] start_q;
  logic [blp_pkg::OffsetW-1:0] window_q;
  logic                        to_end_q;
  logic [PosW-1:0]             pos_q, pos_d;

  work_t work_q, work_d;
  logic  work_vld_q;
  logic  out_vld_q;

  logic [PosW-1:0]                 start_ext, window_ext, room, limit, free_bits;
  logic                            geo_ok, width_bad, exhausted;
  logic [2:0]                      off;
  logic [2:0]                      pad_bits;
  logic [blp_pkg::WidthW-1:0]      width_eff;
  logic [blp_pkg::SpanW-1:0]       mask_lo, val_lo;
  logic [blp_pkg::WidthW:0]        span_sum;
  logic [blp_pkg::ByteCntW-1:0]    nbytes;
  logic                            accept, out_free, emit;

  assign start_ext  = PosW'(start_q);
  assign window_ext = PosW'(window_q);
  assign room       = Avail - start_ext;
  assign geo_ok     = (start_ext <= Avail) && (to_end_q || (window_ext <= room));
  assign limit      = to_end_q ? Avail : (start_ext + window_ext);
  assign free_bits  = limit - pos_q;

  assign off       = pos_q[2:0];
  assign pad_bits  = 3'd0 - off;
  assign width_eff = (item_i.command == blp_pkg::CmdAlign) ?
                     blp_pkg::WidthW'(pad_bits) : item_i.field_width;
  assign width_bad = (item_i.command == blp_pkg::CmdWrite) &&
                     (item_i.field_width > blp_pkg::WidthW'(MAX_FIELD_WIDTH));
  assign exhausted = PosW'(width_eff) > free_bits;

  assign mask_lo  = ~({blp_pkg::SpanW{1'b1}} << width_eff);
  assign val_lo   = (item_i.command == blp_pkg::CmdAlign) ? '0 :
                    (blp_pkg::SpanW'(item_i.field_value) & mask_lo);
  assign span_sum = blp_pkg::WidthW'(off) + width_eff + 7'd7;
  assign nbytes   = (width_eff == '0) ? '0 : blp_pkg::ByteCntW'(span_sum >> 3);

  assign out_free      = !out_vld_q || result_o.ready;
  assign emit          = work_vld_q && out_free;
  assign item_i.ready  = !work_vld_q || (out_free && (work_q.cnt == 3'd1));
  assign accept        = item_i.valid && item_i.ready;

  always_comb begin
    work_d = work_q;
    pos_d  = pos_q;
    if (accept) begin
      work_d.wr     = 1'b0;
      work_d.data   = '0;
      work_d.mask   = '0;
      work_d.index  = '0;
      work_d.cnt    = 3'd1;
      work_d.status = blp_pkg::StatNone;
      if (!geo_ok) begin
        work_d.status = blp_pkg::StatBadGeometry;
      end else if (width_bad) begin
        work_d.status = blp_pkg::StatBadWidth;
      end else if (exhausted) begin
        work_d.status = blp_pkg::StatExhausted;
      end else begin
        pos_d = pos_q + PosW'(width_eff);
        if (nbytes != '0) begin
          work_d.wr    = 1'b1;
          work_d.data  = val_lo << off;
          work_d.mask  = mask_lo << off;
          work_d.index = blp_pkg::IndexW'(pos_q >> 3);
          work_d.cnt   = nbytes;
        end
      end
      work_d.written   = geo_ok ? blp_pkg::CountW'(pos_d - start_ext) : '0;
      work_d.remaining = geo_ok ? blp_pkg::CountW'(limit - pos_d) : '0;
      work_d.aligned   = geo_ok && (pos_d[2:0] == 3'd0);
    end else if (emit) begin
      work_d.data  = work_q.data >> blp_pkg::ByteW;
      work_d.mask  = work_q.mask >> blp_pkg::ByteW;
      work_d.index = work_q.index + 1'b1;
      work_d.cnt   = work_q.cnt - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      window_q   <= '0;
      to_end_q   <= 1'b1;
      pos_q      <= '0;
      work_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blp_pkg::CfgStartOffset: begin
            start_q <= cfg_data_i;
            pos_q   <= PosW'(cfg_data_i);
          end
          blp_pkg::CfgWindowLen: begin
            window_q <= cfg_data_i;
            pos_q    <= start_ext;
          end
          blp_pkg::CfgLengthToEnd: begin
            to_end_q <= cfg_data_i[0];
            pos_q    <= start_ext;
          end
          default: begin
          end
        endcase
      end else begin
        pos_q <= pos_d;
      end
      if (accept) begin
        work_vld_q <= 1'b1;
      end else if (emit && (work_q.cnt == 3'd1)) begin
        work_vld_q <= 1'b0;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (emit) begin
      result_o.byte_write_valid <= work_q.wr;
      result_o.wr_index         <= work_q.index;
      result_o.byte_data        <= work_q.data[blp_pkg::ByteW-1:0];
      result_o.byte_mask        <= work_q.mask[blp_pkg::ByteW-1:0];
      result_o.status           <= work_q.status;
      result_o.last             <= (work_q.cnt == 3'd1);
      result_o.bits_done        <= work_q.written;
      result_o.bits_free        <= work_q.remaining;
      result_o.on_boundary      <= work_q.aligned;
    end
  end

  assign result_o.valid = out_vld_q;

endmodule

`default_nettype wire

@@ verif/bounded_lsb_bit_packer_unit_test.sv @@
`default_nettype none

module bounded_lsb_bit_packer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufferBits     = blp_pkg::BufferBytesDef * 8;
  localparam int unsigned FieldWidthMax  = blp_pkg::MaxFieldWidthDef;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned HalfPhaseItems = 12;
  localparam int unsigned RandomPhases   = 6;

  typedef struct {
    blp_pkg::cmd_e cmd;
    logic [31:0]   value;
    logic [5:0]    width;
  } field_t;

  typedef struct {
    logic             wr;
    logic [11:0]      idx;
    logic [7:0]       data;
    logic [7:0]       mask;
    blp_pkg::status_e st;
    logic             last;
    logic [15:0]      written;
    logic [15:0]      remaining;
    logic             aligned;
  } byte_write_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [blp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [blp_pkg::CfgDataW-1:0] cfg_data_i;

  blp_item_if   item_if ();
  blp_result_if result_if ();

  bounded_lsb_bit_packer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  field_t      field_queue[$];
  byte_write_t due_writes[$];
  field_t      next_field;
  byte_write_t head_write;

  int unsigned cfg_start;
  int unsigned cfg_len;
  bit          cfg_to_end;
  int unsigned bit_pos;

  bit          steady;
  bit          field_taken;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit window_end(output int unsigned lim);
    int unsigned room;
    int unsigned len;
    lim = 0;
    if (cfg_start > BufferBits) return 1'b0;
    room = BufferBits - cfg_start;
    len  = cfg_to_end ? room : cfg_len;
    if (len > room) return 1'b0;
    lim = cfg_start + len;
    return 1'b1;
  endfunction

  function automatic void pack_field(blp_pkg::cmd_e cmd, logic [31:0] val, logic [5:0] width);
    byte_write_t      res[$];
    byte_write_t      r;
    int unsigned      lim;
    int unsigned      nbits;
    int unsigned      left;
    int unsigned      p;
    int unsigned      off;
    int unsigned      n;
    int unsigned      ones;
    logic [31:0]      v;
    bit               ok;
    blp_pkg::status_e err;
    ok    = window_end(lim);
    err   = blp_pkg::StatNone;
    v     = val;
    nbits = width;
    if (!ok) begin
      err = blp_pkg::StatBadGeometry;
    end else if (cmd == blp_pkg::CmdAlign) begin
      v     = '0;
      nbits = (8 - (bit_pos & 7)) & 7;
    end else if (width > FieldWidthMax) begin
      err = blp_pkg::StatBadWidth;
    end
    if (err == blp_pkg::StatNone && nbits > lim - bit_pos) err = blp_pkg::StatExhausted;
    r = '{wr: 1'b0, idx: '0, data: '0, mask: '0, st: err, last: 1'b0,
          written: '0, remaining: '0, aligned: 1'b0};
    if (err == blp_pkg::StatNone) begin
      p    = bit_pos;
      left = nbits;
      while (left > 0) begin
        off = p & 7;
        n   = 8 - off;
        if (n > left) n = left;
        ones   = (1 << n) - 1;
        r.wr   = 1'b1;
        r.idx  = 12'(p >> 3);
        r.data = 8'((v & ones) << off);
        r.mask = 8'(ones << off);
        res.push_back(r);
        v    = v >> n;
        p    += n;
        left -= n;
      end
      bit_pos += nbits;
    end
    if (res.size() == 0) begin
      r.wr = 1'b0;
      res.push_back(r);
    end
    foreach (res[k]) begin
      res[k].last      = (k == res.size() - 1);
      res[k].written   = ok ? 16'(bit_pos - cfg_start) : 16'd0;
      res[k].remaining = ok ? 16'(lim - bit_pos) : 16'd0;
      res[k].aligned   = ok && ((bit_pos & 7) == 0);
      due_writes.push_back(res[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, exp, act);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || field_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        item_if.valid <= 1'b0;
      end else if (field_queue.size() > 0) begin
        next_field = field_queue.pop_front();
        item_if.valid       <= 1'b1;
        item_if.command     <= next_field.cmd;
        item_if.field_value <= next_field.value;
        item_if.field_width <= next_field.width;
        send_gap = pick_gap();
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      field_taken  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      field_taken <= item_if.valid && item_if.ready;
      if (item_if.valid && item_if.ready) begin
        pack_field(blp_pkg::cmd_e'(item_if.command), item_if.field_value,
                   item_if.field_width);
      end
      if (result_if.valid && result_if.ready) begin
        if (due_writes.size() == 0) begin
          $display("%0t unexpected transaction: index %0h data %0h mask %0h status %0h",
                   $realtime, result_if.wr_index, result_if.byte_data,
                   result_if.byte_mask, result_if.status);
          mismatches++;
        end else begin
          head_write = due_writes.pop_front();
          check_field("byte_write_valid", head_write.wr, result_if.byte_write_valid);
          check_field("wr_index", head_write.idx, result_if.wr_index);
          check_field("byte_data", head_write.data, result_if.byte_data);
          check_field("byte_mask", head_write.mask, result_if.byte_mask);
          check_field("status", head_write.st, result_if.status);
          check_field("last", head_write.last, result_if.last);
          check_field("bits_done", head_write.written, result_if.bits_done);
          check_field("bits_free", head_write.remaining, result_if.bits_free);
          check_field("on_boundary", head_write.aligned, result_if.on_boundary);
        end
      end
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_field(input blp_pkg::cmd_e cmd, input logic [31:0] val,
                           input logic [5:0] width);
    field_t f;
    f.cmd   = cmd;
    f.value = val;
    f.width = width;
    field_queue.push_back(f);
  endtask

  task automatic add_random_field();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) add_field(blp_pkg::CmdAlign, $urandom, 6'($urandom));
    else if (r < 23) add_field(blp_pkg::CmdWrite, $urandom, 6'($urandom_range(33, 63)));
    else add_field(blp_pkg::CmdWrite, $urandom, 6'($urandom_range(0, 32)));
  endtask

  task automatic wait_idle();
    while (field_queue.size() != 0 || item_if.valid || due_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input blp_pkg::cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      blp_pkg::CfgStartOffset: cfg_start = data;
      blp_pkg::CfgWindowLen:   cfg_len = data;
      default:                 cfg_to_end = data[0];
    endcase
    bit_pos = cfg_start;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      cfg_write(blp_pkg::CfgStartOffset, 16'($urandom_range(0, 4095)));
      cfg_write(blp_pkg::CfgWindowLen, 16'($urandom));
      cfg_write(blp_pkg::CfgLengthToEnd, 16'd1);
    end else if (sel < 7) begin
      cfg_write(blp_pkg::CfgStartOffset, 16'($urandom_range(0, 64)));
      cfg_write(blp_pkg::CfgWindowLen, 16'($urandom_range(0, 600)));
      cfg_write(blp_pkg::CfgLengthToEnd, 16'd0);
    end else if (sel < 9) begin
      cfg_write(blp_pkg::CfgStartOffset, 16'(BufferBits - $urandom_range(0, 300)));
      cfg_write(blp_pkg::CfgWindowLen, 16'($urandom_range(0, 300)));
      cfg_write(blp_pkg::CfgLengthToEnd, 16'($urandom_range(0, 1)));
    end else begin
      cfg_write(blp_pkg::CfgStartOffset, 16'($urandom));
      cfg_write(blp_pkg::CfgWindowLen, 16'($urandom));
      cfg_write(blp_pkg::CfgLengthToEnd, 16'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = blp_pkg::CfgStartOffset;
    cfg_data_i          = '0;
    item_if.valid       = 1'b0;
    item_if.command     = blp_pkg::CmdWrite;
    item_if.field_value = '0;
    item_if.field_width = '0;
    result_if.ready     = 1'b0;
    cfg_start           = 0;
    cfg_len             = 0;
    cfg_to_end          = 1'b1;
    bit_pos             = 0;
    steady              = 1'b0;
    send_gap            = 0;
    stall_left          = 0;
    mismatches          = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full buffer from offset zero
    cfg_write(blp_pkg::CfgStartOffset, 16'd0);
    cfg_write(blp_pkg::CfgWindowLen, 16'd0);
    cfg_write(blp_pkg::CfgLengthToEnd, 16'd1);
    add_field(blp_pkg::CmdWrite, 32'h0000_0000, 6'd0);
    add_field(blp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd32);
    add_field(blp_pkg::CmdWrite, 32'h0000_0005, 6'd3);
    add_field(blp_pkg::CmdWrite, 32'hA5A5_5A5A, 6'd32);
    add_field(blp_pkg::CmdAlign, 32'hFFFF_FFFF, 6'd63);
    add_field(blp_pkg::CmdAlign, 32'h0000_0000, 6'd0);
    add_field(blp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd33);
    add_field(blp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd63);
    add_field(blp_pkg::CmdWrite, 32'h0000_0000, 6'd1);
    wait_idle();

    // window at the very end of the buffer
    cfg_write(blp_pkg::CfgStartOffset, 16'(BufferBits - 8));
    add_field(blp_pkg::CmdWrite, 32'h0000_001F, 6'd5);
    add_field(blp_pkg::CmdWrite, 32'h0000_000F, 6'd4);
    add_field(blp_pkg::CmdAlign, 32'h0000_0000, 6'd0);
    add_field(blp_pkg::CmdAlign, 32'h0000_0000, 6'd0);
    add_field(blp_pkg::CmdWrite, 32'h0000_0000, 6'd0);
    add_field(blp_pkg::CmdWrite, 32'h0000_0001, 6'd1);
    wait_idle();
    cfg_write(blp_pkg::CfgStartOffset, 16'(BufferBits));
    add_field(blp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd0);
    wait_idle();

    // start past the buffer
    cfg_write(blp_pkg::CfgStartOffset, 16'(BufferBits + 1));
    add_field(blp_pkg::CmdWrite, 32'h0000_00FF, 6'd8);
    wait_idle();
    cfg_write(blp_pkg::CfgStartOffset, 16'hFFFF);
    add_field(blp_pkg::CmdAlign, 32'h0000_0000, 6'd0);
    wait_idle();

    // explicit window length
    cfg_write(blp_pkg::CfgStartOffset, 16'd3);
    cfg_write(blp_pkg::CfgLengthToEnd, 16'd0);
    add_field(blp_pkg::CmdWrite, 32'h0000_0001, 6'd1);
    add_field(blp_pkg::CmdAlign, 32'h0000_0000, 6'd0);
    wait_idle();
    cfg_write(blp_pkg::CfgWindowLen, 16'(BufferBits - 3));
    add_field(blp_pkg::CmdWrite, $urandom, 6'd32);
    wait_idle();
    cfg_write(blp_pkg::CfgWindowLen, 16'(BufferBits - 2));
    add_field(blp_pkg::CmdWrite, 32'h0000_0003, 6'd2);
    wait_idle();
    cfg_write(blp_pkg::CfgWindowLen, 16'hFFFF);
    add_field(blp_pkg::CmdWrite, 32'h0000_0003, 6'd2);
    wait_idle();
    cfg_write(blp_pkg::CfgLengthToEnd, 16'hFFFF);
    add_field(blp_pkg::CmdWrite, 32'h0000_007F, 6'd7);
    wait_idle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      random_config();
      repeat (HalfPhaseItems) add_random_field();
      // sender holds off until all results of the first half are back
      wait_idle();
      repeat (HalfPhaseItems) add_random_field();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/blp_pkg.sv
hw/rtl/blp_item_if.sv
hw/rtl/blp_result_if.sv
hw/rtl/bounded_lsb_bit_packer_unit.sv
verif/bounded_lsb_bit_packer_unit_test.sv
